[src/vt4_pkg.sv]
`default_nettype none

package vt4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int LANES     = 4;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int COEF_N    = LANES * LANES;
   localparam int IDX_W     = $clog2(COEF_N);

   localparam int REQ_DATA_W = ((IDX_W + (LANES + 1) * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = LANES * COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_XFORM = 1'b1
   } op_type;

   // pipeline advance strobes, one per lane stage
   typedef struct packed {
      logic en_mul;
      logic en_sum;
      logic en_sat;
   } stage_ctrl_type;

endpackage

`default_nettype wire

[src/vt4_lane.sv]
`default_nettype none

module vt4_lane (
   input  wire                     clock,
   input  vt4_pkg::stage_ctrl_type ctrl,
   input  vt4_pkg::coord_type      vtx [vt4_pkg::LANES],
   input  vt4_pkg::coord_type      col [vt4_pkg::LANES],
   output vt4_pkg::coord_type      result,
   output logic                    sat
);

   logic signed [vt4_pkg::PROD_W-1:0]  prod_ff [vt4_pkg::LANES];
   logic signed [vt4_pkg::PROD_W-1:0]  prod_in [vt4_pkg::LANES];
   logic signed [vt4_pkg::SUM_W-1:0]   sum_ff;
   logic signed [vt4_pkg::SUM_W-1:0]   sum_in;
   logic signed [vt4_pkg::SUM_W-1:0]   shifted;
   logic [vt4_pkg::SUM_W-vt4_pkg::COORD_W:0] upper;
   vt4_pkg::coord_type                 result_ff;
   vt4_pkg::coord_type                 result_in;
   logic                               sat_ff;
   logic                               sat_in;

   always_comb begin
      for (int k = 0; k < vt4_pkg::LANES; k++) begin
         prod_in[k] = vtx[k] * col[k];
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < vt4_pkg::LANES; k++) begin
         sum_in = sum_in + vt4_pkg::SUM_W'(prod_ff[k]);
      end
   end

   // floor shift, then clip to 32 bits when the upper bits disagree with the sign
   always_comb begin
      shifted = sum_ff >>> vt4_pkg::FRAC_BITS;
      upper   = shifted[vt4_pkg::SUM_W-1:vt4_pkg::COORD_W-1];
      if ((&upper) || !(|upper)) begin
         result_in = shifted[vt4_pkg::COORD_W-1:0];
         sat_in    = 1'b0;
      end else begin
         result_in = shifted[vt4_pkg::SUM_W-1]
                   ? {1'b1, {(vt4_pkg::COORD_W-1){1'b0}}}
                   : {1'b0, {(vt4_pkg::COORD_W-1){1'b1}}};
         sat_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en_mul) begin
         for (int k = 0; k < vt4_pkg::LANES; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      if (ctrl.en_sum) begin
         sum_ff <= sum_in;
      end
      if (ctrl.en_sat) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire

[src/vt4_merge.sv]
`default_nettype none

module vt4_merge (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 lane_valid,
   input  vt4_pkg::coord_type                  lane_result [vt4_pkg::LANES],
   input  wire  [vt4_pkg::LANES-1:0]           lane_sat,
   output logic                                take,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [vt4_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic [0:0]                          rsp_tuser   // saturated
);

   logic                              valid_ff;
   logic [vt4_pkg::RSP_DATA_W-1:0]    data_ff;
   logic [vt4_pkg::RSP_DATA_W-1:0]    data_in;
   logic                              sat_ff;

   assign take = !valid_ff || rsp_tready;

   always_comb begin
      for (int j = 0; j < vt4_pkg::LANES; j++) begin
         data_in[j*vt4_pkg::COORD_W +: vt4_pkg::COORD_W] = lane_result[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= lane_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && lane_valid) begin
         data_ff <= data_in;
         sat_ff  <= |lane_sat;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = sat_ff;

endmodule

`default_nettype wire

[src/vertex_transform_4x4_unit.sv]
`default_nettype none

// Homogeneous 4x4 vertex transform, signed Q16.16. A transaction with
// req_tuser = 1 carries a vertex (x, y, z, w) that is multiplied as a row
// vector by the stored matrix: out_j = sum_k in_k * m[k*4+j], each exact sum
// floor-shifted by 16 and clipped to 32 bits, with rsp_tuser set when any
// component clipped. A transaction with req_tuser = 0 writes coefficient
// m[coef_index] = coef_value and gives no response; it applies to every
// vertex accepted after it. The matrix is all zeros after reset. One
// transaction is accepted per clock while req_tready is high; a vertex
// reaches rsp_* through the product registers (loaded at the accepting
// edge), then the sum and clip registers in four column lanes, then the
// output register; stalls on rsp_tready squeeze out pipeline bubbles first.

module vertex_transform_4x4_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // coef_index, coef_value, in_x, in_y, in_z, in_w, zero pad
   input  wire  [vt4_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire  [0:0]                        req_tuser,  // op
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [vt4_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic [0:0]                        rsp_tuser   // saturated
);

   localparam int VAL_LO = vt4_pkg::IDX_W;
   localparam int VTX_LO = vt4_pkg::IDX_W + vt4_pkg::COORD_W;

   vt4_pkg::coord_type         coef_ff [vt4_pkg::COEF_N];
   vt4_pkg::coord_type         vtx [vt4_pkg::LANES];
   vt4_pkg::coord_type         lane_result [vt4_pkg::LANES];
   logic [vt4_pkg::LANES-1:0]  lane_sat;
   logic [vt4_pkg::IDX_W-1:0]  coef_index;
   vt4_pkg::coord_type         coef_value;
   vt4_pkg::op_type            op;
   vt4_pkg::stage_ctrl_type    ctrl;
   logic                       mul_valid_ff;
   logic                       sum_valid_ff;
   logic                       sat_valid_ff;
   logic                       take;
   logic                       accept;

   assign coef_index = req_tdata[vt4_pkg::IDX_W-1:0];
   assign coef_value = req_tdata[VAL_LO +: vt4_pkg::COORD_W];
   assign op         = vt4_pkg::op_type'(req_tuser[0]);

   always_comb begin
      for (int k = 0; k < vt4_pkg::LANES; k++) begin
         vtx[k] = req_tdata[VTX_LO + k*vt4_pkg::COORD_W +: vt4_pkg::COORD_W];
      end
   end

   // each stage moves when it is empty or the stage after it moves
   assign ctrl.en_sat = !sat_valid_ff || take;
   assign ctrl.en_sum = !sum_valid_ff || ctrl.en_sat;
   assign ctrl.en_mul = !mul_valid_ff || ctrl.en_sum;
   assign req_tready  = ctrl.en_mul;
   assign accept      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         sat_valid_ff <= 1'b0;
         for (int i = 0; i < vt4_pkg::COEF_N; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         if (ctrl.en_mul) begin
            mul_valid_ff <= accept && (op == vt4_pkg::OP_XFORM);
         end
         if (ctrl.en_sum) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (ctrl.en_sat) begin
            sat_valid_ff <= sum_valid_ff;
         end
         if (accept && (op == vt4_pkg::OP_LOAD)) begin
            coef_ff[coef_index] <= coef_value;
         end
      end
   end

   for (genvar j = 0; j < vt4_pkg::LANES; j++) begin : g_lane
      vt4_pkg::coord_type col [vt4_pkg::LANES];

      for (genvar k = 0; k < vt4_pkg::LANES; k++) begin : g_col
         assign col[k] = coef_ff[k*vt4_pkg::LANES + j];
      end

      vt4_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .vtx    (vtx),
         .col    (col),
         .result (lane_result[j]),
         .sat    (lane_sat[j])
      );
   end

   vt4_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_valid  (sat_valid_ff),
      .lane_result (lane_result),
      .lane_sat    (lane_sat),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (mul_valid_ff && sum_valid_ff && sat_valid_ff && rsp_tvalid))
      else $error("input stalled while the pipeline has a bubble");

   a_xform_enters : assert property (@(posedge clock) disable iff (reset)
      (accept && (op == vt4_pkg::OP_XFORM)) |=> mul_valid_ff)
      else $error("accepted vertex did not enter the multiply stage");

   a_load_no_result : assert property (@(posedge clock) disable iff (reset)
      (accept && (op == vt4_pkg::OP_LOAD)) |=> !mul_valid_ff)
      else $error("coefficient load produced a pipeline entry");

   a_load_written : assert property (@(posedge clock) disable iff (reset)
      (accept && (op == vt4_pkg::OP_LOAD))
      |=> (coef_ff[$past(coef_index)] == $past(coef_value)))
      else $error("coefficient load not stored");

endmodule

`default_nettype wire
